@@ rtl/core/cths_pkg.sv @@
// Shared constants, types and LCG helpers for the crypt table string hash.
// No dependencies; imported by the top level.
package cths_pkg;

    localparam int          C_NUM_TABLES     = 5;
    localparam int          C_SECTION_WORDS  = 256;
    localparam int          C_WORD_W         = 32;
    localparam int          C_LCG_W          = 22;
    localparam int          C_FOLD_W         = 24;
    localparam int          C_PROD_W         = 29;

    localparam logic [31:0] C_SEED_ONE_INIT  = 32'h7FED_7FED;
    localparam logic [31:0] C_SEED_TWO_INIT  = 32'hEEEE_EEEE;
    localparam logic [31:0] C_SEED_TWO_ADD   = 32'd3;

    localparam logic [C_LCG_W-1:0]  C_LCG_START = 22'h10_0001;
    localparam logic [C_LCG_W-1:0]  C_LCG_MOD   = 22'h2A_AAAB;
    localparam logic [C_PROD_W-1:0] C_LCG_MULT  = 29'd125;
    localparam logic [C_PROD_W-1:0] C_LCG_INC   = 29'd3;
    // three times the modulus is 2^23 + 1
    localparam logic [C_FOLD_W-1:0] C_FOLD_MOD  = 24'h80_0001;

    localparam logic [7:0]  C_CASE_OFFSET    = 8'h20;

    typedef enum logic {
        MODE_FILL,
        MODE_RUN
    } t_mode;

    typedef enum logic [1:0] {
        PH_HI_MUL,
        PH_HI_RED,
        PH_LO_MUL,
        PH_LO_RED
    } t_fill_phase;

    // First half of an LCG step: s*125+3, folded modulo 2^23+1 (below 3*mod).
    function automatic logic [C_FOLD_W-1:0] lcg_fold(input logic [C_LCG_W-1:0] s);
        logic [C_PROD_W-1:0] prod;
        logic [C_FOLD_W-1:0] diff;
        prod = C_PROD_W'(s) * C_LCG_MULT + C_LCG_INC;
        diff = {1'b0, prod[22:0]} - {18'd0, prod[28:23]};
        if (diff[C_FOLD_W-1]) begin
            diff = diff + C_FOLD_MOD;
        end
        return diff;
    endfunction

    // Second half: bring a value below 3*mod into 0..mod-1.
    function automatic logic [C_LCG_W-1:0] lcg_reduce(input logic [C_FOLD_W-1:0] r);
        logic [C_FOLD_W-1:0] mod1;
        logic [C_FOLD_W-1:0] mod2;
        logic [C_FOLD_W-1:0] res;
        mod1 = C_FOLD_W'(C_LCG_MOD);
        mod2 = {mod1[C_FOLD_W-2:0], 1'b0};
        if (r >= mod2) begin
            res = r - mod2;
        end else if (r >= mod1) begin
            res = r - mod1;
        end else begin
            res = r;
        end
        return res[C_LCG_W-1:0];
    endfunction

endpackage

@@ rtl/core/cths_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cths_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 1280,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/crypt_table_string_hash.sv @@
// Crypt table string hash: one character word in, one 32-bit hash per string.
// The last word passes stage 1; the output register then captures its hash.
// Throughput: one character word per cycle when not stalled; table read on accept.
// Reset: synchronous, active low; seeds reload and the table RAM is swept with
// the LCG contents, one word per pass through PH_HI_MUL, PH_HI_RED, PH_LO_MUL
// and PH_LO_RED; no word is accepted during the sweep.
module crypt_table_string_hash #(
    parameter int NUM_TABLES = cths_pkg::C_NUM_TABLES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: tdata = char_code[7:0], table_select[10:8], zero pad[15:11]
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_s_tlast,   // last_char
    // master side: tdata = hash_value[31:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata
);
    import cths_pkg::*;

    localparam int DEPTH  = NUM_TABLES * C_SECTION_WORDS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SEC_W  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;

    // ---------------------------------------------------------------------
    // Table sweep after reset. Each word needs two LCG steps, and each step
    // is split into multiply-and-fold, then final reduction.
    // Sections run innermost, columns outermost, as the table is defined.
    // ---------------------------------------------------------------------
    t_mode               r_mode,  n_mode;
    t_fill_phase         r_phase, n_phase;
    logic [7:0]          r_col,   n_col;
    logic [SEC_W-1:0]    r_sec,   n_sec;
    logic [C_LCG_W-1:0]  r_lcg,   n_lcg;
    logic [C_FOLD_W-1:0] r_fold,  n_fold;
    logic [15:0]         r_hi,    n_hi;
    logic [C_LCG_W-1:0]  w_reduced;
    logic                w_wr_en;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [C_WORD_W-1:0] w_wr_data;

    assign w_reduced = lcg_reduce(r_fold);
    assign w_wr_addr = ADDR_W'({r_sec, r_col});
    assign w_wr_data = {r_hi, w_reduced[15:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_FILL;
            r_phase <= PH_HI_MUL;
            r_col   <= '0;
            r_sec   <= '0;
            r_lcg   <= C_LCG_START;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_col   <= n_col;
            r_sec   <= n_sec;
            r_lcg   <= n_lcg;
        end
        r_fold <= n_fold;
        r_hi   <= n_hi;
    end

    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        n_col   = r_col;
        n_sec   = r_sec;
        n_lcg   = r_lcg;
        n_fold  = r_fold;
        n_hi    = r_hi;
        w_wr_en = 1'b0;
        if (r_mode == MODE_FILL) begin
            case (r_phase)
                PH_HI_MUL: begin
                    n_fold  = lcg_fold(r_lcg);
                    n_phase = PH_HI_RED;
                end
                PH_HI_RED: begin
                    n_lcg   = w_reduced;
                    n_hi    = w_reduced[15:0];
                    n_phase = PH_LO_MUL;
                end
                PH_LO_MUL: begin
                    n_fold  = lcg_fold(r_lcg);
                    n_phase = PH_LO_RED;
                end
                PH_LO_RED: begin
                    // write the finished word and step to the next slot
                    n_lcg   = w_reduced;
                    w_wr_en = 1'b1;
                    n_phase = PH_HI_MUL;
                    if (32'(r_sec) == NUM_TABLES - 1) begin
                        n_sec = '0;
                        n_col = r_col + 8'd1;
                        if (r_col == 8'hFF) begin
                            n_mode = MODE_RUN;
                        end
                    end else begin
                        n_sec = r_sec + SEC_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_HI_MUL;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Stage 0: accept a word, uppercase the byte, issue the table read.
    // An out-of-range section reads as zero; address 0 keeps the read legal.
    // ---------------------------------------------------------------------
    logic [7:0]          w_in_char;
    logic [2:0]          w_in_sec;
    logic [7:0]          w_upper;
    logic                w_sec_ok;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic                w_out_free;
    logic                w_advance;
    logic                w_accept;
    logic                w_fire;
    logic [C_WORD_W-1:0] w_rd_data;

    assign w_in_char = i_s_tdata[7:0];
    assign w_in_sec  = i_s_tdata[10:8];
    assign w_sec_ok  = 32'(w_in_sec) < NUM_TABLES;

    always_comb begin
        if (w_in_char inside {[8'h61:8'h7A]}) begin
            w_upper = w_in_char - C_CASE_OFFSET;
        end else begin
            w_upper = w_in_char;
        end
    end

    assign w_rd_addr = w_sec_ok ? ADDR_W'({w_in_sec[SEC_W-1:0], w_upper}) : '0;

    // Stage 1 stalls only when it holds a last word and the output register
    // is full and not being drained; the RAM read register then holds too.
    logic                r_p1_valid;
    logic [7:0]          r_p1_char;
    logic                r_p1_sec_ok;
    logic                r_p1_last;

    assign w_out_free = !o_m_tvalid || i_m_tready;
    assign w_advance  = !(r_p1_valid && r_p1_last && !w_out_free);
    assign o_s_tready = (r_mode == MODE_RUN) && w_advance;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_fire     = r_p1_valid && w_advance;

    cths_ram #(
        .WIDTH (C_WORD_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_advance),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (w_advance) begin
            r_p1_valid <= w_accept;
        end
        if (w_advance) begin
            r_p1_char   <= w_upper;
            r_p1_sec_ok <= w_sec_ok;
            r_p1_last   <= i_s_tlast;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: mix the table word into both seeds. The seed-two sum that
    // does not depend on the new seed one is formed alongside it.
    // ---------------------------------------------------------------------
    logic [31:0] r_seed_one;
    logic [31:0] r_seed_two;
    logic [31:0] w_word;
    logic [31:0] w_s1;
    logic [31:0] w_s2_part;
    logic [31:0] w_s2;

    assign w_word    = r_p1_sec_ok ? w_rd_data : '0;
    assign w_s1      = w_word ^ (r_seed_one + r_seed_two);
    assign w_s2_part = 32'(r_p1_char) + r_seed_two + {r_seed_two[26:0], 5'd0}
                       + C_SEED_TWO_ADD;
    assign w_s2      = w_s1 + w_s2_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_one <= C_SEED_ONE_INIT;
            r_seed_two <= C_SEED_TWO_INIT;
        end else if (w_fire) begin
            if (r_p1_last) begin
                // reload for the next string
                r_seed_one <= C_SEED_ONE_INIT;
                r_seed_two <= C_SEED_TWO_INIT;
            end else begin
                r_seed_one <= w_s1;
                r_seed_two <= w_s2;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output register: holds the hash until the sink takes the word.
    // ---------------------------------------------------------------------
    logic        r_out_valid;
    logic [31:0] r_out_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_p1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire && r_p1_last) begin
            r_out_hash <= w_s1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_hash;

`ifndef SYNTH
    // No table read is served before the sweep has written every word.
    a_no_accept_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_FILL) |-> !o_s_tready)
        else $error("word accepted while the table sweep is running");

    // A stalled stage 1 keeps its word and its table data.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && !w_advance) |=> (r_p1_valid && $stable(r_p1_char)
                                        && $stable(w_rd_data)))
        else $error("stage 1 lost its word during a stall");

    // A completed string leaves both seeds at their initial values.
    a_seed_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_p1_last) |=> (r_seed_one == C_SEED_ONE_INIT
                                   && r_seed_two == C_SEED_TWO_INIT))
        else $error("seeds not reloaded after the last character");

    // The sweep only writes inside the table.
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (32'(w_wr_addr) < DEPTH && r_mode == MODE_FILL))
        else $error("table write outside the sweep or beyond the table");
`endif

endmodule

@@ sim/tb_crypt_table_string_hash.sv @@
// Self-checking bench for the crypt table string hash: character words in, one hash per string.
// Depends on cths_pkg and crypt_table_string_hash; holds its own table and seed predictor.
`timescale 1ns / 100ps

module tb_crypt_table_string_hash;
    import cths_pkg::*;

    localparam int   TABLE_DEPTH   = C_NUM_TABLES * C_SECTION_WORDS;
    // the watchdog limit lies far above the reset sweep and the longest hold-off
    localparam int   STALL_LIMIT   = 20000;
    localparam int   TAIL_CYCLES   = 12;
    localparam int   HOLD_CYCLES   = 400;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // char_code[7:0], table_select[10:8], zero pad[15:11]
    logic        i_s_tlast;   // last_char
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // hash_value[31:0]

    // Predictor state: the crypt table, the running seeds and the hashes still owed.
    logic [31:0] crypt_rom [TABLE_DEPTH];
    logic [31:0] run_seed_one;
    logic [31:0] run_seed_two;
    logic [31:0] hash_expected [$];

    int error_count   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    crypt_table_string_hash i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Generate the crypt table: the LCG runs column by column, two steps per word,
    // the first giving the high half and the second the low half.
    task automatic build_crypt_rom();
        longint unsigned lcg;
        logic [31:0]     hi_half;
        lcg = C_LCG_START;
        for (int col = 0; col < C_SECTION_WORDS; col++) begin
            for (int sec = 0; sec < C_NUM_TABLES; sec++) begin
                lcg     = (lcg * 125 + 3) % C_LCG_MOD;
                hi_half = {lcg[15:0], 16'h0000};
                lcg     = (lcg * 125 + 3) % C_LCG_MOD;
                crypt_rom[sec * C_SECTION_WORDS + col] = hi_half | {16'h0000, lcg[15:0]};
            end
        end
    endtask

    // Advance the seeds by one character; on the last one, owe its hash and reload.
    function automatic void hash_char(input logic [7:0] code, input logic [2:0] sel,
                                      input logic last);
        logic [7:0]  ch;
        logic [31:0] mix_word;
        logic [31:0] next_one;
        logic [31:0] next_two;
        ch = code;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            ch = ch - C_CASE_OFFSET;
        end
        // sections past the end of the table read as zero
        mix_word = (sel < C_NUM_TABLES) ? crypt_rom[sel * C_SECTION_WORDS + ch] : 32'd0;
        next_one = mix_word ^ (run_seed_one + run_seed_two);
        next_two = {24'd0, ch} + next_one + run_seed_two + (run_seed_two << 5) + C_SEED_TWO_ADD;
        run_seed_one = next_one;
        run_seed_two = next_two;
        if (last) begin
            hash_expected.insert(hash_expected.size(), run_seed_one);
            run_seed_one = C_SEED_ONE_INIT;
            run_seed_two = C_SEED_TWO_INIT;
        end
    endfunction

    // Offer one character word, hold it until taken, then idle as the phase asks.
    // Valid stays high into the next call when no gap is drawn.
    task automatic send_char(input logic [7:0] code, input logic [2:0] sel, input logic last);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'd0, sel, code};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        hash_char(code, sel, last);
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Pick a character, leaning towards letters so case folding is well covered.
    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        case ($urandom_range(9))
            0, 1:    c = 8'h41 + 8'($urandom_range(25));
            2, 3:    c = CHAR_LOWER_A + 8'($urandom_range(25));
            4:       c = $urandom_range(1) ? 8'hFF : 8'h00;
            default: c = 8'($urandom_range(255));
        endcase
        return c;
    endfunction

    // One string of random content; mostly a fixed in-range section, now and then
    // one beyond the table, and as noise a section that wanders from word to word.
    task automatic send_random_string();
        int         len;
        logic [2:0] sel;
        logic       wander;
        len    = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
        sel    = ($urandom_range(9) == 0) ? 3'($urandom_range(7, C_NUM_TABLES))
                                          : 3'($urandom_range(C_NUM_TABLES - 1));
        wander = ($urandom_range(9) == 0);
        for (int k = 0; k < len; k++) begin
            if (wander) sel = 3'($urandom_range(7));
            send_char(pick_char(), sel, k == len - 1);
        end
    endtask

    // Drop valid and wait until every owed hash has come back.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (hash_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [7:0] mixed [4];
        mixed = '{8'h48, 8'h61, 8'h53, 8'h68};   // mixed-case four-letter word
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // single-character strings at both ends of the lower-case range, then a zero byte
        send_char(CHAR_LOWER_A, 3'd0, 1'b1);
        send_char(CHAR_LOWER_Z, 3'd1, 1'b1);
        send_char(8'h00, 3'd0, 1'b1);
        // upper-case bounds, then the bytes just outside the lower-case range
        send_char(8'h41, 3'd2, 1'b0);
        send_char(8'h5A, 3'd2, 1'b1);
        send_char(8'h60, 3'd3, 1'b0);
        send_char(8'h7B, 3'd3, 1'b1);
        // byte extremes in the top section
        send_char(8'h00, 3'd4, 1'b0);
        send_char(8'hFF, 3'd4, 1'b1);
        // sections past the end of the table read a zero word
        send_char(8'h7F, 3'd5, 1'b0);
        send_char(8'h80, 3'd5, 1'b1);
        send_char(8'hFF, 3'd7, 1'b1);
        send_char(8'hC1, 3'd6, 1'b1);
        for (int k = 0; k < 4; k++) begin
            send_char(mixed[k], 3'd0, k == 3);
        end
        wait_drained();
    endtask

    task automatic test_random_phase(input int items, input int idle_pct, input int stall_pct);
        int sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < items) begin
            send_random_string();
            sent = sent + 1 + $urandom_range(0, 0);
        end
    endtask

    // Block the output for a long stretch while words keep coming, so the
    // pipeline fills and input ready drops.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        repeat (60) send_char(pick_char(), 3'($urandom_range(C_NUM_TABLES - 1)),
                              $urandom_range(2) == 0);
        send_char(pick_char(), 3'd1, 1'b1);
        wait_drained();
    endtask

    // Pause the sender until all hashes are back, then carry on with random strings.
    task automatic test_drain_pause();
        send_idle_pct  = 10;
        recv_stall_pct = 30;
        repeat (8) send_random_string();
        wait_drained();
        @(posedge i_clk);
        repeat (8) send_random_string();
    endtask

    // Receiver: random stalls per phase, and long hold-offs on request.
    always @(posedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen  = hold_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result check against the oldest owed hash, plus the no-progress watchdog.
    always @(posedge i_clk) begin : result_check
        logic [31:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (hash_expected.size() == 0) begin
                $display("%0t: unexpected hash word, expected none, actual %08h",
                         $time, o_m_tdata);
                error_count++;
            end else begin
                want = hash_expected.pop_front();
                if (o_m_tdata !== want) begin
                    $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                             $time, want, o_m_tdata);
                    error_count++;
                end
            end
        end
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[crypt_table_string_hash] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        build_crypt_rom();
        run_seed_one = C_SEED_ONE_INIT;
        run_seed_two = C_SEED_TWO_INIT;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(25, 0, 0);
        test_random_phase(25, 62, 0);
        test_random_phase(25, 0, 62);
        test_random_phase(25, 29, 29);
        test_backpressure();
        test_drain_pause();
        test_random_phase(10, 0, 0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[crypt_table_string_hash] OK");
        end else begin
            $display("[crypt_table_string_hash] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/cths_pkg.sv
rtl/core/cths_ram.sv
rtl/core/crypt_table_string_hash.sv
sim/tb_crypt_table_string_hash.sv
